/* rtl/erm_pkg.sv */
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and register map of the event rate meter.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int DEF_TOTAL_WIDTH    = 48;
    localparam int DEF_RATE_FRAC_BITS = 16;

    localparam int CNT_W   = 32;
    localparam int ALPHA_W = 16;
    localparam int EVT_W   = 16;
    localparam int OUT_W   = 48;
    localparam int PROD_W  = CNT_W + ALPHA_W;
    localparam int N_AVG   = 3;
    localparam int IDX_W   = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] RST_INV_INTERVAL = 16'd13107;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_SHORT  = 16'd5243;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_MID    = 16'd1083;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_LONG   = 16'd363;

    localparam logic [IDX_W-1:0] AVG_SHORT = 2'd0;
    localparam logic [IDX_W-1:0] AVG_MID   = 2'd1;
    localparam logic [IDX_W-1:0] AVG_LONG  = 2'd2;

    typedef enum logic [1:0] {
        REG_INV_INTERVAL,
        REG_ALPHA_SHORT,
        REG_ALPHA_MID,
        REG_ALPHA_LONG
    } t_reg_idx;

    typedef struct packed {
        logic [EVT_W-1:0] event_count;
        logic             tick;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] total_count;
        logic [OUT_W-1:0] rate_short;
        logic [OUT_W-1:0] rate_mid;
        logic [OUT_W-1:0] rate_long;
    } t_out;

    typedef struct packed {
        logic [ALPHA_W-1:0]            inv_interval;
        logic [N_AVG-1:0][ALPHA_W-1:0] alpha;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_INST,
        S_INST,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_UPD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_INST,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef struct packed {
        logic             accept;
        logic             mul_en;
        t_mul_sel         mul_sel;
        logic             inst_load;
        logic             diff_en;
        logic             acc_lo;
        logic             acc_hi;
        logic             upd;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic started;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/erm_cfg.sv */
// ----------------------------------------------------------------------------
// erm_cfg
// APB register file: tick reciprocal and the three smoothing factors.
// ----------------------------------------------------------------------------
module erm_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [erm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [erm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [erm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output erm_pkg::t_cfg                      o_cfg
);
    import erm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;

    assign w_reg  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_interval     <= RST_INV_INTERVAL;
            r_cfg.alpha[AVG_SHORT] <= RST_ALPHA_SHORT;
            r_cfg.alpha[AVG_MID]   <= RST_ALPHA_MID;
            r_cfg.alpha[AVG_LONG]  <= RST_ALPHA_LONG;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_INV_INTERVAL: r_cfg.inv_interval     <= pwdata[ALPHA_W-1:0];
                REG_ALPHA_SHORT:  r_cfg.alpha[AVG_SHORT] <= pwdata[ALPHA_W-1:0];
                REG_ALPHA_MID:    r_cfg.alpha[AVG_MID]   <= pwdata[ALPHA_W-1:0];
                REG_ALPHA_LONG:   r_cfg.alpha[AVG_LONG]  <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_INV_INTERVAL: prdata = APB_DATA_W'(r_cfg.inv_interval);
            REG_ALPHA_SHORT:  prdata = APB_DATA_W'(r_cfg.alpha[AVG_SHORT]);
            REG_ALPHA_MID:    prdata = APB_DATA_W'(r_cfg.alpha[AVG_MID]);
            REG_ALPHA_LONG:   prdata = APB_DATA_W'(r_cfg.alpha[AVG_LONG]);
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/erm_ctrl.sv */
// ----------------------------------------------------------------------------
// erm_ctrl
// Sequencer: event add, instant rate, then one update pass per average.
// ----------------------------------------------------------------------------
module erm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_tick,
    output logic              o_in_ready,
    input  erm_pkg::t_dp_sts  i_sts,
    output erm_pkg::t_dp_cmd  o_cmd
);
    import erm_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_INST;
        o_cmd.idx     = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_in_tick ? S_MUL_INST : S_OUT;
                end
            end
            S_MUL_INST: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_INST;
                n_state       = S_INST;
            end
            S_INST: begin
                // first tick loads the averages directly in the datapath
                o_cmd.inst_load = 1'b1;
                n_idx           = '0;
                n_state         = i_sts.started ? S_DIFF : S_OUT;
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state       = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                o_cmd.acc_lo  = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_hi = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_idx == AVG_LONG) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_OUT: begin
                // wait here while the previous result is still unclaimed
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/erm_dp.sv */
// ----------------------------------------------------------------------------
// erm_dp
// Counters, shared 32x16 multiplier, moving averages and result register.
// ----------------------------------------------------------------------------
module erm_dp #(
    parameter int TOTAL_WIDTH    = erm_pkg::DEF_TOTAL_WIDTH,
    parameter int RATE_FRAC_BITS = erm_pkg::DEF_RATE_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  erm_pkg::t_in      i_in,
    input  erm_pkg::t_cfg     i_cfg,
    input  erm_pkg::t_dp_cmd  i_cmd,
    output erm_pkg::t_dp_sts  o_sts,
    output erm_pkg::t_out     o_out,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import erm_pkg::*;

    localparam int RW   = CNT_W + RATE_FRAC_BITS;
    localparam int AW   = RW + ALPHA_W;
    localparam int SH_L = (RATE_FRAC_BITS >= ALPHA_W) ? RATE_FRAC_BITS - ALPHA_W : 0;
    localparam int SH_R = (RATE_FRAC_BITS < ALPHA_W) ? ALPHA_W - RATE_FRAC_BITS : 0;
    localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (ALPHA_W - 1);

    logic [TOTAL_WIDTH-1:0] r_total;
    logic [CNT_W-1:0]       r_cnt;
    logic [RW-1:0]          r_avg [N_AVG];
    logic                   r_started;
    logic [RW-1:0]          r_inst;
    logic [RW-1:0]          r_diff;
    logic                   r_up;
    logic [PROD_W-1:0]      r_prod;
    logic [AW-1:0]          r_acc;
    t_out                   r_out;
    logic                   r_out_valid;

    logic [CNT_W:0]         w_cnt_sum;
    logic [CNT_W-1:0]       w_mul_a;
    logic [ALPHA_W-1:0]     w_mul_b;
    logic [63:0]            w_shift;
    logic [RW-1:0]          w_inst;
    logic [RW-1:0]          w_avg_sel;
    logic [RW-1:0]          w_step;

    assign w_cnt_sum = {1'b0, r_cnt} + (CNT_W + 1)'(i_in.event_count);
    assign w_shift   = (64'(r_prod) << SH_L) >> SH_R;
    assign w_inst    = RW'(w_shift);
    assign w_avg_sel = r_avg[i_cmd.idx];
    assign w_step    = r_acc[AW-1:ALPHA_W];

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_INST: begin
                w_mul_a = r_cnt;
                w_mul_b = i_cfg.inv_interval;
            end
            MUL_LO: begin
                w_mul_a = r_diff[CNT_W-1:0];
                w_mul_b = i_cfg.alpha[i_cmd.idx];
            end
            MUL_HI: begin
                w_mul_a = CNT_W'(r_diff[RW-1:CNT_W]);
                w_mul_b = i_cfg.alpha[i_cmd.idx];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < N_AVG; k++) begin
                r_avg[k] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_total <= r_total + TOTAL_WIDTH'(i_in.event_count);
                r_cnt   <= w_cnt_sum[CNT_W] ? '1 : w_cnt_sum[CNT_W-1:0];
            end
            if (i_cmd.inst_load) begin
                r_cnt <= '0;
                if (!r_started) begin
                    r_started <= 1'b1;
                    for (int k = 0; k < N_AVG; k++) begin
                        r_avg[k] <= w_inst;
                    end
                end
            end
            if (i_cmd.upd) begin
                r_avg[i_cmd.idx] <= r_up ? w_avg_sel + w_step : w_avg_sel - w_step;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if (i_cmd.inst_load) begin
            r_inst <= w_inst;
        end
        if (i_cmd.diff_en) begin
            r_up   <= (r_inst >= w_avg_sel);
            r_diff <= (r_inst >= w_avg_sel) ? r_inst - w_avg_sel : w_avg_sel - r_inst;
        end
        // step = (diff * alpha + half) >> 16, built from two partial products
        if (i_cmd.acc_lo) begin
            r_acc <= AW'(r_prod) + ROUND_HALF;
        end
        if (i_cmd.acc_hi) begin
            r_acc <= r_acc + (AW'(r_prod) << CNT_W);
        end
        if (i_cmd.out_load) begin
            r_out.total_count <= OUT_W'(r_total);
            r_out.rate_short  <= OUT_W'(r_avg[AVG_SHORT]);
            r_out.rate_mid    <= OUT_W'(r_avg[AVG_MID]);
            r_out.rate_long   <= OUT_W'(r_avg[AVG_LONG]);
        end
    end

    assign o_sts.started  = r_started;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out          = r_out;
    assign o_out_valid    = r_out_valid;

endmodule

/* rtl/event_rate_meter_ewma.sv */
// ----------------------------------------------------------------------------
// event_rate_meter_ewma
// Event rate meter with one-, five- and fifteen-minute moving averages.
// ----------------------------------------------------------------------------
// Input items (i_valid/o_ready) carry an event count and a tick flag; every
// item yields one result (o_valid/i_ready) with the running total and the
// three averaged rates in unsigned Q32.16 events per second.
// Items are handled one at a time through a single 32x16 multiplier:
//   no tick:              the events are added and the result is loaded
//   first tick:           the averages load the instant rate
//   later ticks:          one instant multiply, then an update pass for
//                         each of the three averages
// The result sits in an output register, so a new item is taken as soon as
// the sequencer is back in idle even if the last result is still waiting.
// When the receiver stalls with a result pending, the next result waits in
// the sequencer until the output register frees up.
// Reset clears the counters and averages and restores the register defaults.
// Registers on APB at byte 0x0 inv_interval, 0x4/0x8/0xC alphas; pready is
// always high and writes should only happen while the block is idle.
// ----------------------------------------------------------------------------
module event_rate_meter_ewma #(
    parameter int TOTAL_WIDTH    = erm_pkg::DEF_TOTAL_WIDTH,
    parameter int RATE_FRAC_BITS = erm_pkg::DEF_RATE_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  erm_pkg::t_in                       i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output erm_pkg::t_out                      o_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [erm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [erm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [erm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import erm_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    erm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    erm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_tick  (i_data.tick),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    erm_dp #(
        .TOTAL_WIDTH    (TOTAL_WIDTH),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_data),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_data),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready)
    );

    // one item in flight: no second transfer right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in flight");

    // loading a result always presents it on the next cycle
    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("loaded result not presented");

    // a result is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && o_valid) |-> i_ready)
        else $error("pending result overwritten");

    // averages are only marked started by an instant-rate load
    a_start_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_sts.started) |-> $past(w_cmd.inst_load))
        else $error("averages started without a tick");

    // update passes stay within the three averages
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd |-> (w_cmd.idx == AVG_SHORT || w_cmd.idx == AVG_MID ||
                       w_cmd.idx == AVG_LONG))
        else $error("average index out of range");

endmodule

/* bench/tb_event_rate_meter_ewma.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_rate_meter_ewma
// Self-checking bench for the event rate meter. A directed table of event
// counts and ticks goes first, then random phases under different register
// settings, a long receiver stall and a full-scale burst between ticks. Every
// result is compared field by field against a local model of the meter (typed rows: against the table).
// ----------------------------------------------------------------------------
module tb_event_rate_meter_ewma;
    import erm_pkg::*;

    localparam int N_REGS         = N_AVG + 1;
    localparam int N_ROWS         = 16;
    localparam int N_PHASES       = 6;
    localparam int PRESSURE_PHASE = 2;
    localparam int STEADY_PHASE   = 3;
    localparam int PHASE_ITEMS    = 180;
    localparam int BURST_ITEMS    = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_SHOWN        = 10;

    typedef struct packed {
        logic [EVT_W-1:0] event_count;
        logic             tick;
        logic             typed;
        logic [OUT_W-1:0] total;
        logic [OUT_W-1:0] rate;
    } t_row;

    // typed rows expect the same value on all three averages
    localparam t_row DIRECTED [N_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, 48'd0,     48'd0},
        '{16'hFFFF, 1'b0, 1'b1, 48'd65535, 48'd0},
        '{16'h0001, 1'b1, 1'b1, 48'd65536, 48'd858980352}, // first tick loads 65536 * 13107
        '{16'h0000, 1'b1, 1'b0, 48'd0,     48'd0},         // empty tick, averages decay
        '{16'hFFFF, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'hFFFF, 1'b0, 1'b0, 48'd0,     48'd0},
        '{16'hFFFF, 1'b0, 1'b0, 48'd0,     48'd0},
        '{16'hFFFF, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'h0001, 1'b0, 1'b0, 48'd0,     48'd0},
        '{16'h0001, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'h0000, 1'b0, 1'b0, 48'd0,     48'd0},
        '{16'h8000, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'h5555, 1'b0, 1'b0, 48'd0,     48'd0},
        '{16'hAAAA, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'h0000, 1'b1, 1'b0, 48'd0,     48'd0},
        '{16'hFFFF, 1'b1, 1'b0, 48'd0,     48'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in                   i_data;
    logic                  o_valid;
    logic                  i_ready;
    t_out                  o_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // meter model state and register copy
    logic [OUT_W-1:0]   m_total;
    logic [CNT_W-1:0]   m_since;
    logic [OUT_W-1:0]   m_avg [N_AVG];
    logic               m_started;
    logic [ALPHA_W-1:0] c_regs [N_REGS];

    t_out pending_results [$];

    int n_mismatch = 0;
    int n_items    = 0;
    int n_ticks    = 0;
    int n_results  = 0;
    int n_settings = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit steady   = 1'b0;

    event_rate_meter_ewma DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        n_mismatch++;
        if (n_mismatch <= N_SHOWN)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // adds the events, handles a tick and returns the meter readout
    function automatic t_out meter_advance(t_in it);
        logic [CNT_W:0]     since_sum;
        logic [OUT_W-1:0]   inst;
        logic [63:0]        diff;
        logic [63:0]        delta;
        logic [ALPHA_W-1:0] a;
        logic               up;
        t_out               res;
        m_total = m_total + it.event_count;
        since_sum = m_since + it.event_count;
        m_since = since_sum[CNT_W] ? '1 : since_sum[CNT_W-1:0];
        if (it.tick) begin
            inst = m_since * c_regs[REG_INV_INTERVAL];
            m_since = '0;
            for (int k = 0; k < N_AVG; k++) begin
                a = c_regs[int'(REG_ALPHA_SHORT) + k];
                if (!m_started) begin
                    m_avg[k] = inst;
                end else begin
                    up = (inst >= m_avg[k]);
                    diff = up ? 64'(inst - m_avg[k]) : 64'(m_avg[k] - inst);
                    // alpha * diff / 2^16, half rounded up in magnitude
                    delta = (diff >> ALPHA_W) * 64'(a)
                          + ((64'(diff[ALPHA_W-1:0]) * 64'(a) + (64'd1 << (ALPHA_W - 1)))
                             >> ALPHA_W);
                    m_avg[k] = up ? m_avg[k] + delta[OUT_W-1:0] : m_avg[k] - delta[OUT_W-1:0];
                end
            end
            m_started = 1'b1;
        end
        res.total_count = m_total;
        res.rate_short  = m_avg[AVG_SHORT];
        res.rate_mid    = m_avg[AVG_MID];
        res.rate_long   = m_avg[AVG_LONG];
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_setting();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return ALPHA_W'($urandom);
        endcase
    endfunction

    task automatic send_item(t_in it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(meter_advance(it));
        n_items++;
        if (it.tick)
            n_ticks++;
    endtask

    task automatic end_phase();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // psel stays high across back-to-back transfers, verify_settings drops it
    task automatic reg_write(t_reg_idx r, logic [ALPHA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        c_regs[r] = v;
    endtask

    task automatic verify_settings();
        logic [APB_DATA_W-1:0] d;
        for (int i = 0; i < N_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {t_reg_idx'(i), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            while (!pready) @(negedge i_clk);
            d = prdata;
            if (d[ALPHA_W-1:0] !== c_regs[i])
                note_mismatch("register readback", c_regs[i], d);
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_settings(logic [ALPHA_W-1:0] inv, logic [ALPHA_W-1:0] a_short,
                                  logic [ALPHA_W-1:0] a_mid, logic [ALPHA_W-1:0] a_long);
        reg_write(REG_INV_INTERVAL, inv);
        reg_write(REG_ALPHA_SHORT, a_short);
        reg_write(REG_ALPHA_MID, a_mid);
        reg_write(REG_ALPHA_LONG, a_long);
        n_settings++;
        verify_settings();
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : sink
        int unsigned n;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (steady) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", '0, o_data.total_count);
            end else begin
                want = pending_results.pop_front();
                if (o_data.total_count !== want.total_count)
                    note_mismatch("total_count", want.total_count, o_data.total_count);
                if (o_data.rate_short !== want.rate_short)
                    note_mismatch("rate_short", want.rate_short, o_data.rate_short);
                if (o_data.rate_mid !== want.rate_mid)
                    note_mismatch("rate_mid", want.rate_mid, o_data.rate_mid);
                if (o_data.rate_long !== want.rate_long)
                    note_mismatch("rate_long", want.rate_long, o_data.rate_long);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_in         it;
        t_out        typed_res;
        int unsigned tick_pct;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        c_regs[REG_INV_INTERVAL] = RST_INV_INTERVAL;
        c_regs[REG_ALPHA_SHORT]  = RST_ALPHA_SHORT;
        c_regs[REG_ALPHA_MID]    = RST_ALPHA_MID;
        c_regs[REG_ALPHA_LONG]   = RST_ALPHA_LONG;
        m_total   = '0;
        m_since   = '0;
        m_started = 1'b0;
        for (int k = 0; k < N_AVG; k++) begin
            m_avg[k] = '0;
        end
        verify_settings();

        for (int row = 0; row < N_ROWS; row++) begin
            it.event_count = DIRECTED[row].event_count;
            it.tick        = DIRECTED[row].tick;
            send_item(it);
            if (DIRECTED[row].typed) begin
                typed_res = '{DIRECTED[row].total, DIRECTED[row].rate,
                              DIRECTED[row].rate, DIRECTED[row].rate};
                pending_results[pending_results.size() - 1] = typed_res;
            end
        end
        end_phase();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_settings('1, '1, '1, '1);
                1: write_settings('0, '0, '0, '0);
                default: write_settings(pick_setting(), pick_setting(), pick_setting(),
                                        pick_setting());
            endcase
            tick_pct = $urandom_range(5, 50);
            steady   = (ph == STEADY_PHASE);
            hold_req = (ph == PRESSURE_PHASE);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0: it.event_count = '0;
                    1: it.event_count = '1;
                    2: it.event_count = EVT_W'($urandom_range(0, 15));
                    default: it.event_count = EVT_W'($urandom);
                endcase
                it.tick = ($urandom_range(0, 99) < tick_pct);
                send_item(it);
            end
            end_phase();
        end
        steady = 1'b0;

        // long full-scale burst without a tick, then tick at full scale
        write_settings('1, pick_setting(), pick_setting(), pick_setting());
        steady = 1'b1;
        repeat (BURST_ITEMS) send_item(t_in'{16'hFFFF, 1'b0});
        send_item(t_in'{16'h0000, 1'b1});
        send_item(t_in'{16'hFFFF, 1'b1});
        end_phase();
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch("results never delivered", pending_results.size(), 0);

        $display("covered %0d items with %0d ticks under %0d register settings, %0d results",
                 n_items, n_ticks, n_settings, n_results);
        $display("incl. zero and full-scale settings, a long output stall, a full-scale burst");
        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/erm_pkg.sv
rtl/erm_cfg.sv
rtl/erm_ctrl.sv
rtl/erm_dp.sv
rtl/event_rate_meter_ewma.sv
bench/tb_event_rate_meter_ewma.sv
